// ----- rtl/matrix_axis_max_reduction_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the matrix max reduction block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_AXIS_MAX_REDUCTION_ASSERT_SVH
`define MATRIX_AXIS_MAX_REDUCTION_ASSERT_SVH

// same-cycle implication
`define MXR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mxr assertion failed");

// next-cycle implication
`define MXR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mxr assertion failed");

`endif

// ----- rtl/mxr_pkg.sv -----
// ----------------------------------------------------------------------------
// mxr_pkg
// Shared constants, types and helpers of the matrix max reduction block.
// ----------------------------------------------------------------------------
package mxr_pkg;

    localparam int MAX_COLS   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VAL_W      = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ELEM_W     = 32;
    localparam int OUT_W      = 32;
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W      = $clog2(MAX_COLS + 1);
    localparam int ROW_W      = 16;
    localparam int MODE_W     = 2;
    localparam int COLREG_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [MODE_W-1:0] MODE_COL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROW = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE = 2'd0,
        REG_ROWS = 2'd1,
        REG_COLS = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_WHOLE,
        OP_COL,
        OP_ROW
    } op_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DRAIN_RD,
        BK_DRAIN_OUT
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic             seed;
        logic             emit;
        logic             drain;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] group;
        logic [VAL_W-1:0] value;
    } entry_t;

    function automatic logic [OUT_W-1:0] extend_out(input logic signed [VAL_W-1:0] v);
        return OUT_W'(v);
    endfunction

endpackage

// ----- rtl/mxr_if.sv -----
// ----------------------------------------------------------------------------
// Channel interfaces
// Element, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mxr_elem_if;
    logic                      valid;
    logic                      ready;
    logic [mxr_pkg::ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface mxr_result_if;
    logic                      valid;
    logic                      ready;
    logic [mxr_pkg::OUT_W-1:0] max_value;
    logic [mxr_pkg::ROW_W-1:0] group_index;
    logic                      last_of_run;

    modport source (output valid, output max_value, output group_index,
                    output last_of_run, input ready);
    modport sink   (input valid, input max_value, input group_index,
                    input last_of_run, output ready);
endinterface

interface mxr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mxr_pkg::CFG_IDX_W-1:0]  index;
    logic [mxr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/matrix_axis_max_reduction.sv -----
// ----------------------------------------------------------------------------
// matrix_axis_max_reduction
// Streaming maximum of a row-major matrix over the whole matrix, per column
// or per row.
// ----------------------------------------------------------------------------
// Elements are accepted at one per cycle in all modes while the queue has
// room; each passes a 4-entry queue and one compare stage, so the element
// closing a group is registered in a queue slot, the compare stage and the
// result register. Row and whole-matrix results come straight from the
// compare stage and stall it only while the result register is full. In
// column mode the last element of the matrix drains the column store: per
// column, a registered read of the store, then a result register load that
// waits on backpressure, while the back end pops nothing and the queue takes
// at most four more elements before element.ready drops. Any write to a
// defined register restarts the matrix at element (0,0); the column store
// needs no clearing after reset: row 0 of a run writes all the drain reads.
// ----------------------------------------------------------------------------
module matrix_axis_max_reduction (
    input  logic         clk,
    input  logic         rst_n,
    mxr_cfg_if.sink      cfg,
    mxr_elem_if.sink     element,
    mxr_result_if.source result
);

    mxr_pkg::entry_t f2q_entry;
    logic            f2q_valid;
    logic            f2q_ready;
    mxr_pkg::entry_t q2b_entry;
    logic            q2b_valid;
    logic            q2b_ready;

    mxr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .element    (element),
        .push_entry (f2q_entry),
        .push_valid (f2q_valid),
        .push_ready (f2q_ready)
    );

    mxr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (f2q_entry),
        .in_valid  (f2q_valid),
        .in_ready  (f2q_ready),
        .out_entry (q2b_entry),
        .out_valid (q2b_valid),
        .out_ready (q2b_ready)
    );

    mxr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (q2b_entry),
        .pop_valid (q2b_valid),
        .pop_ready (q2b_ready),
        .result    (result)
    );

endmodule

// ----- rtl/mxr_front.sv -----
// ----------------------------------------------------------------------------
// mxr_front
// Holds configuration and matrix position; tags each element for the back end.
// ----------------------------------------------------------------------------
module mxr_front (
    input  logic              clk,
    input  logic              rst_n,
    mxr_cfg_if.sink           cfg,
    mxr_elem_if.sink          element,
    output mxr_pkg::entry_t   push_entry,
    output logic              push_valid,
    input  logic              push_ready
);

    logic [mxr_pkg::MODE_W-1:0]   mode_reg,      mode_next;
    logic [mxr_pkg::ROW_W-1:0]    row_total_reg, row_total_next;
    logic [mxr_pkg::COLREG_W-1:0] col_total_reg, col_total_next;
    logic [mxr_pkg::COL_W-1:0]    col_pos_reg,   col_pos_next;
    logic [mxr_pkg::ROW_W-1:0]    row_pos_reg,   row_pos_next;

    logic [mxr_pkg::CNT_W-1:0]    cols_eff;
    logic [mxr_pkg::ROW_W-1:0]    rows_eff;
    logic [mxr_pkg::COL_W-1:0]    col_cur;
    logic                         last_col;
    logic                         last_row;
    logic                         accept;
    logic                         cfg_hit;
    mxr_pkg::op_t                 op;

    assign cfg.ready     = 1'b1;
    assign element.ready = push_ready;
    assign push_valid    = element.valid;
    assign accept        = element.valid && push_ready;

    always_comb
    begin
        if (col_total_reg == '0)
            cols_eff = mxr_pkg::CNT_W'(1);
        else if (32'(col_total_reg) > mxr_pkg::MAX_COLS)
            cols_eff = mxr_pkg::CNT_W'(mxr_pkg::MAX_COLS);
        else
            cols_eff = mxr_pkg::CNT_W'(col_total_reg);
    end

    assign rows_eff = (row_total_reg == '0) ? mxr_pkg::ROW_W'(1) : row_total_reg;

    assign col_cur  = (mxr_pkg::CNT_W'(col_pos_reg) >= cols_eff)
                    ? mxr_pkg::COL_W'(cols_eff - mxr_pkg::CNT_W'(1)) : col_pos_reg;
    assign last_col = ((mxr_pkg::CNT_W+1)'(col_pos_reg) + (mxr_pkg::CNT_W+1)'(1))
                      >= (mxr_pkg::CNT_W+1)'(cols_eff);
    assign last_row = ((mxr_pkg::ROW_W+1)'(row_pos_reg) + (mxr_pkg::ROW_W+1)'(1))
                      >= (mxr_pkg::ROW_W+1)'(rows_eff);

    always_comb
    begin
        if (mode_reg == mxr_pkg::MODE_COL)
            op = mxr_pkg::OP_COL;
        else if (mode_reg == mxr_pkg::MODE_ROW)
            op = mxr_pkg::OP_ROW;
        else
            op = mxr_pkg::OP_WHOLE;
    end

    always_comb
    begin
        push_entry       = '0;
        push_entry.op    = op;
        push_entry.col   = col_cur;
        push_entry.value = element.element_value[mxr_pkg::VAL_W-1:0];
        unique case (op)
            mxr_pkg::OP_COL:
            begin
                push_entry.seed  = (row_pos_reg == '0);
                push_entry.drain = last_col && last_row;
            end
            mxr_pkg::OP_ROW:
            begin
                push_entry.seed  = (col_pos_reg == '0);
                push_entry.emit  = last_col;
                push_entry.last  = last_row;
                push_entry.group = row_pos_reg;
            end
            default:
            begin
                push_entry.seed  = (row_pos_reg == '0) && (col_pos_reg == '0);
                push_entry.emit  = last_col && last_row;
                push_entry.last  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        row_total_next = row_total_reg;
        col_total_next = col_total_reg;
        cfg_hit        = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                mxr_pkg::REG_MODE:
                begin
                    mode_next = cfg.data[mxr_pkg::MODE_W-1:0];
                    cfg_hit   = 1'b1;
                end
                mxr_pkg::REG_ROWS:
                begin
                    row_total_next = cfg.data[mxr_pkg::ROW_W-1:0];
                    cfg_hit        = 1'b1;
                end
                mxr_pkg::REG_COLS:
                begin
                    col_total_next = cfg.data[mxr_pkg::COLREG_W-1:0];
                    cfg_hit        = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (cfg_hit)
        begin
            col_pos_next = '0;
            row_pos_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + mxr_pkg::ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_cur + mxr_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            row_total_reg <= mxr_pkg::ROW_W'(1);
            col_total_reg <= mxr_pkg::COLREG_W'(1);
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            row_total_reg <= row_total_next;
            col_total_reg <= col_total_next;
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
        end
    end

endmodule

// ----- rtl/mxr_queue.sv -----
// ----------------------------------------------------------------------------
// mxr_queue
// Short FIFO of tagged elements between the front and back ends.
// ----------------------------------------------------------------------------
module mxr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  mxr_pkg::entry_t in_entry,
    input  logic            in_valid,
    output logic            in_ready,
    output mxr_pkg::entry_t out_entry,
    output logic            out_valid,
    input  logic            out_ready
);

    mxr_pkg::entry_t          slot_reg [mxr_pkg::QDEPTH];
    logic [mxr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mxr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mxr_pkg::QPTR_W:0]   count_reg,  count_next;
    logic                       push;
    logic                       pop;

    assign in_ready  = (count_reg != (mxr_pkg::QPTR_W+1)'(mxr_pkg::QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + mxr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + mxr_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (mxr_pkg::QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (mxr_pkg::QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/mxr_back.sv -----
// ----------------------------------------------------------------------------
// mxr_back
// Running and per-column maxima, column drain and the result register.
// ----------------------------------------------------------------------------
module mxr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mxr_pkg::entry_t pop_entry,
    input  logic            pop_valid,
    output logic            pop_ready,
    mxr_result_if.source    result
);

    mxr_pkg::back_state_t state_reg, state_next;

    logic signed [mxr_pkg::VAL_W-1:0] col_store [mxr_pkg::MAX_COLS];
    logic signed [mxr_pkg::VAL_W-1:0] rd_data_reg;

    mxr_pkg::entry_t                  s1_entry_reg;
    logic                             s1_valid_reg;
    logic signed [mxr_pkg::VAL_W-1:0] running_max_reg;
    logic                             last_wr_valid_reg;
    logic [mxr_pkg::COL_W-1:0]        last_wr_addr_reg;
    logic signed [mxr_pkg::VAL_W-1:0] last_wr_data_reg;
    logic [mxr_pkg::COL_W-1:0]        drain_idx_reg;
    logic [mxr_pkg::COL_W-1:0]        drain_last_reg;
    logic                             out_valid_reg;
    logic [mxr_pkg::OUT_W-1:0]        out_value_reg, out_value_next;
    logic [mxr_pkg::ROW_W-1:0]        out_group_reg, out_group_next;
    logic                             out_last_reg,  out_last_next;

    logic signed [mxr_pkg::VAL_W-1:0] s1_value;
    logic signed [mxr_pkg::VAL_W-1:0] col_old;
    logic signed [mxr_pkg::VAL_W-1:0] col_new;
    logic signed [mxr_pkg::VAL_W-1:0] row_new;
    logic                             out_free;
    logic                             s1_fire;
    logic                             pop;
    logic                             mem_we;
    logic                             mem_re;
    logic [mxr_pkg::COL_W-1:0]        mem_raddr;
    logic                             drain_start;
    logic                             drain_load;
    logic                             drain_done;
    logic                             out_load;

    assign s1_value = s1_entry_reg.value;
    assign out_free = !out_valid_reg || result.ready;

    assign col_old = (last_wr_valid_reg && (last_wr_addr_reg == s1_entry_reg.col))
                   ? last_wr_data_reg : rd_data_reg;
    assign col_new = (s1_entry_reg.seed || (s1_value > col_old)) ? s1_value : col_old;
    assign row_new = (s1_entry_reg.seed || (s1_value > running_max_reg))
                   ? s1_value : running_max_reg;

    assign s1_fire     = s1_valid_reg && (state_reg == mxr_pkg::BK_RUN)
                         && (!s1_entry_reg.emit || out_free);
    assign drain_start = s1_fire && s1_entry_reg.drain;
    assign pop_ready   = (state_reg == mxr_pkg::BK_RUN)
                         && (!s1_valid_reg || s1_fire) && !drain_start;
    assign pop         = pop_valid && pop_ready;
    assign drain_load  = (state_reg == mxr_pkg::BK_DRAIN_OUT) && out_free;
    assign drain_done  = (drain_idx_reg == drain_last_reg);

    assign mem_we    = s1_fire && (s1_entry_reg.op == mxr_pkg::OP_COL);
    assign mem_re    = pop || (state_reg == mxr_pkg::BK_DRAIN_RD);
    assign mem_raddr = (state_reg == mxr_pkg::BK_DRAIN_RD) ? drain_idx_reg : pop_entry.col;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mxr_pkg::BK_RUN:
            begin
                if (drain_start)
                    state_next = mxr_pkg::BK_DRAIN_RD;
            end
            mxr_pkg::BK_DRAIN_RD:
            begin
                state_next = mxr_pkg::BK_DRAIN_OUT;
            end
            mxr_pkg::BK_DRAIN_OUT:
            begin
                if (out_free)
                    state_next = drain_done ? mxr_pkg::BK_RUN : mxr_pkg::BK_DRAIN_RD;
            end
            default:
            begin
                state_next = mxr_pkg::BK_RUN;
            end
        endcase
    end

    // result register load
    always_comb
    begin
        out_load       = 1'b0;
        out_value_next = out_value_reg;
        out_group_next = out_group_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            mxr_pkg::BK_RUN:
            begin
                if (s1_fire && s1_entry_reg.emit)
                begin
                    out_load       = 1'b1;
                    out_value_next = mxr_pkg::extend_out(row_new);
                    out_group_next = s1_entry_reg.group;
                    out_last_next  = s1_entry_reg.last;
                end
            end
            mxr_pkg::BK_DRAIN_OUT:
            begin
                if (drain_load)
                begin
                    out_load       = 1'b1;
                    out_value_next = mxr_pkg::extend_out(rd_data_reg);
                    out_group_next = mxr_pkg::ROW_W'(drain_idx_reg);
                    out_last_next  = drain_done;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.max_value   = out_value_reg;
    assign result.group_index = out_group_reg;
    assign result.last_of_run = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            col_store[s1_entry_reg.col] <= col_new;
        if (mem_re)
            rd_data_reg <= col_store[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_entry_reg <= pop_entry;
        if (s1_fire && (s1_entry_reg.op != mxr_pkg::OP_COL))
            running_max_reg <= row_new;
        if (mem_we)
        begin
            last_wr_addr_reg <= s1_entry_reg.col;
            last_wr_data_reg <= col_new;
        end
        if (drain_start)
        begin
            drain_idx_reg  <= '0;
            drain_last_reg <= s1_entry_reg.col;
        end
        else if (drain_load && !drain_done)
        begin
            drain_idx_reg <= drain_idx_reg + mxr_pkg::COL_W'(1);
        end
        if (out_load)
        begin
            out_value_reg <= out_value_next;
            out_group_reg <= out_group_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= mxr_pkg::BK_RUN;
            s1_valid_reg      <= 1'b0;
            last_wr_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (mem_we)
                last_wr_valid_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/mxr_checker.sv -----
// ----------------------------------------------------------------------------
// mxr_checker
// Port-level checks of the matrix max reduction block, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_axis_max_reduction_assert.svh"

module mxr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      elem_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [mxr_pkg::OUT_W-1:0] res_value,
    input logic [mxr_pkg::ROW_W-1:0] res_group,
    input logic                      res_last,
    input logic                      cfg_ready
);

    `MXR_ASSERT_NEXT(result_beat_holds, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_group) && $stable(res_last))
    `MXR_ASSERT_NOW(empty_after_reset, $rose(rst_n), !res_valid && elem_ready)
    `MXR_ASSERT_NOW(cfg_always_ready, 1'b1, cfg_ready)

endmodule

bind matrix_axis_max_reduction mxr_checker u_mxr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .elem_ready (element.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_value  (result.max_value),
    .res_group  (result.group_index),
    .res_last   (result.last_of_run),
    .cfg_ready  (cfg.ready)
);
